>>> hw/rtl/vtbm_pkg.sv
// shared types and constants of the volume table block mapper
`timescale 1ns / 1ps

package vtbm_pkg;

  localparam int MAX_VOLUMES          = 8;
  localparam int SECTORS_PER_CYLINDER = 16;

  localparam int IDX_W = (MAX_VOLUMES > 1) ? $clog2(MAX_VOLUMES) : 1;
  localparam int CNT_W = $clog2(MAX_VOLUMES + 1);

  localparam logic [1:0] REQ_CREATE    = 2'd0;
  localparam logic [1:0] REQ_DELETE    = 2'd1;
  localparam logic [1:0] REQ_TRANSLATE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_VOL   = 2'd2;
  localparam logic [1:0] ST_BAD_BLOCK = 2'd3;

  typedef struct packed {
    logic [1:0]  vol_type;
    logic [15:0] sector_count;
    logic [3:0]  first_sector;
    logic [9:0]  first_cylinder;
  } vtbm_entry_t;

  typedef struct packed {
    logic write_en;
    logic shift_en;
  } vtbm_cell_ctrl_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  first_cylinder;
    logic [3:0]  first_sector;
    logic [15:0] sector_count;
    logic [1:0]  vol_type;
    logic [2:0]  volume_index;
    logic [15:0] block_number;
  } vtbm_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  new_index;
    logic [12:0] cylinder;
    logic [3:0]  sector;
    logic [3:0]  volume_count;
  } vtbm_rsp_t;

endpackage

>>> hw/rtl/vtbm_req_if.sv
// request channel of the volume table block mapper
`timescale 1ns / 1ps

interface vtbm_req_if;
  import vtbm_pkg::*;

  logic      valid;
  logic      ready;
  vtbm_req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/vtbm_rsp_if.sv
// response channel of the volume table block mapper
`timescale 1ns / 1ps

interface vtbm_rsp_if;
  import vtbm_pkg::*;

  logic      valid;
  logic      ready;
  vtbm_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/vtbm_cell.sv
// one table slot: loads a new entry or takes its upper neighbor's entry
`timescale 1ns / 1ps

module vtbm_cell (
  input  logic                     clk,
  input  vtbm_pkg::vtbm_cell_ctrl_t ctrl,
  input  vtbm_pkg::vtbm_entry_t    write_data,
  input  vtbm_pkg::vtbm_entry_t    upper_entry,
  output vtbm_pkg::vtbm_entry_t    entry
);
  import vtbm_pkg::*;

  vtbm_entry_t slot;

  always_ff @(posedge clk) begin
    if (ctrl.write_en) begin
      slot <= write_data;
    end else if (ctrl.shift_en) begin
      slot <= upper_entry;
    end
  end

  assign entry = slot;

endmodule

>>> hw/rtl/volume_table_block_mapper.sv
// Volume table block mapper.
// Requests arrive on the req channel, one result per request leaves on rsp;
// both are valid/ready, a transaction completes when valid and ready are high.
// Create appends a volume to a row of cells, delete removes one and the cells
// above it each take their upper neighbor's entry in the same cycle, translate
// reads one cell and adds first sector and block, the quotient by the sectors
// per cylinder goes into the cylinder, the remainder is the sector.
// The result is in the output register in the cycle after the request
// transaction. Throughput: one request per cycle, set by the single output
// register; the table update and the translate path fit in that cycle.
// A new request is taken while the held result is being taken in the same
// cycle. When the receiver stalls, the result holds and req.ready drops.
// Reset (rst, synchronous) empties the table and drops rsp.valid; entry
// contents are not cleared, only slots below the volume count are ever read.
`timescale 1ns / 1ps

module volume_table_block_mapper (
  input logic        clk,
  input logic        rst,
  vtbm_req_if.sink   req,
  vtbm_rsp_if.source rsp
);
  import vtbm_pkg::*;

  logic            rsp_valid;
  vtbm_rsp_t       rsp_data;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  vtbm_rsp_t       result;

  vtbm_entry_t     entries   [MAX_VOLUMES];
  vtbm_cell_ctrl_t cell_ctrl [MAX_VOLUMES];
  vtbm_entry_t     new_entry;
  vtbm_entry_t     sel_entry;
  logic [IDX_W-1:0] vol_idx;
  logic [16:0]     sum;
  logic            accept;
  logic            vol_ok;
  logic            create_ok;
  logic            delete_ok;

  assign accept    = req.valid && req.ready;
  assign req.ready = !rsp_valid || rsp.ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign new_entry.first_cylinder = req.data.first_cylinder;
  assign new_entry.first_sector   = req.data.first_sector;
  assign new_entry.sector_count   = req.data.sector_count;
  assign new_entry.vol_type       = req.data.vol_type;

  assign vol_ok    = 32'(req.data.volume_index) < 32'(count);
  assign create_ok = (req.data.req_type == REQ_CREATE) && (32'(count) < MAX_VOLUMES);
  assign delete_ok = (req.data.req_type == REQ_DELETE) && vol_ok;
  assign vol_idx   = IDX_W'(req.data.volume_index);
  assign sel_entry = entries[vol_idx];
  assign sum       = 17'(sel_entry.first_sector) + 17'(req.data.block_number);

  // row of cells, each one looks at its upper neighbor, the top one at itself
  for (genvar i = 0; i < MAX_VOLUMES; i++) begin : g_cell
    vtbm_entry_t upper;

    if (i == MAX_VOLUMES - 1) begin : g_top
      assign upper = entries[i];
    end else begin : g_mid
      assign upper = entries[i+1];
    end

    always_comb begin
      cell_ctrl[i].write_en = accept && create_ok && (32'(count) == i);
      cell_ctrl[i].shift_en = accept && delete_ok && (32'(req.data.volume_index) <= i);
    end

    vtbm_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl[i]),
      .write_data  (new_entry),
      .upper_entry (upper),
      .entry       (entries[i])
    );
  end

  always_comb begin
    result     = '0;
    count_next = count;
    case (req.data.req_type)
      REQ_CREATE: begin
        if (create_ok) begin
          result.new_index = 3'(count);
          count_next       = count + 1'b1;
        end else begin
          result.status = ST_FULL;
        end
      end
      REQ_DELETE: begin
        if (delete_ok) begin
          count_next = count - 1'b1;
        end else begin
          result.status = ST_BAD_VOL;
        end
      end
      REQ_TRANSLATE: begin
        if (!vol_ok) begin
          result.status = ST_BAD_VOL;
        end else if (req.data.block_number >= sel_entry.sector_count) begin
          result.status = ST_BAD_BLOCK;
        end else begin
          result.cylinder = 13'(sel_entry.first_cylinder)
                          + 13'(sum / SECTORS_PER_CYLINDER);
          result.sector   = 4'(sum % SECTORS_PER_CYLINDER);
        end
      end
      default: begin
        result.status = ST_OK;
      end
    endcase
    result.volume_count = 4'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      count     <= '0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
      count     <= count_next;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data <= result;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_VOLUMES)
    else $error("volume count above table size");

  a_create_grows: assert property (@(posedge clk) disable iff (rst)
    accept && create_ok |=> count == $past(count) + 1'b1)
    else $error("create did not grow the table");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (rst)
    accept && delete_ok |=> count == $past(count) - 1'b1)
    else $error("delete did not shrink the table");

  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.data.volume_count == 4'(count))
    else $error("held result disagrees with volume count");
`endif

endmodule

>>> tb/volume_table_block_mapper_tb.sv
// testbench for the volume table block mapper: directed, stall and random request streams
`timescale 1ns / 1ps

module volume_table_block_mapper_tb;
  import vtbm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 1000;
  localparam int RANDOM_REQUESTS = 1000;
  localparam int PHASE_LEN = 200;

  logic clk;
  logic rst;

  vtbm_req_if req_if ();
  vtbm_rsp_if rsp_if ();

  volume_table_block_mapper DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .rsp(rsp_if.source)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // predicted table contents, advanced on every accepted request
  vtbm_entry_t volume_table [MAX_VOLUMES];
  int unsigned volume_total;
  vtbm_rsp_t   pending_results [$];

  // sector counts of the volumes the stimulus has created so far
  int unsigned planned_sizes [$];

  int  mismatches;
  int  idle_cycles;
  bit  no_gaps;
  int  rsp_hold_cycles;

  function automatic vtbm_rsp_t map_request(input vtbm_req_t r);
    vtbm_rsp_t   res;
    int unsigned vol;
    int unsigned pos;
    int unsigned offset;
    res = '0;
    vol = 32'(r.volume_index);
    case (r.req_type)
      REQ_CREATE: begin
        if (volume_total >= MAX_VOLUMES) begin
          res.status = ST_FULL;
        end else begin
          volume_table[volume_total].first_cylinder = r.first_cylinder;
          volume_table[volume_total].first_sector   = r.first_sector;
          volume_table[volume_total].sector_count   = r.sector_count;
          volume_table[volume_total].vol_type       = r.vol_type;
          res.new_index = 3'(volume_total);
          volume_total++;
        end
      end
      REQ_DELETE: begin
        if (vol >= volume_total) begin
          res.status = ST_BAD_VOL;
        end else begin
          for (pos = vol + 1; pos < volume_total; pos++)
            volume_table[pos - 1] = volume_table[pos];
          volume_total--;
        end
      end
      REQ_TRANSLATE: begin
        if (vol >= volume_total) begin
          res.status = ST_BAD_VOL;
        end else if (r.block_number >= volume_table[vol].sector_count) begin
          res.status = ST_BAD_BLOCK;
        end else begin
          offset = 32'(volume_table[vol].first_sector) + 32'(r.block_number);
          res.cylinder = 13'(32'(volume_table[vol].first_cylinder)
                             + offset / SECTORS_PER_CYLINDER);
          res.sector = 4'(offset % SECTORS_PER_CYLINDER);
        end
      end
      default: ;
    endcase
    res.volume_count = 4'(volume_total);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    // keep the log short if the block is badly broken
    if (mismatches < 100)
      $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // result checking and prediction, both on the values seen at the edge
  always @(posedge clk) begin
    vtbm_rsp_t want;
    if (!rst) begin
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          check_field("status", 16'(rsp_if.data.status), 16'(want.status));
          check_field("new_index", 16'(rsp_if.data.new_index), 16'(want.new_index));
          check_field("cylinder", 16'(rsp_if.data.cylinder), 16'(want.cylinder));
          check_field("sector", 16'(rsp_if.data.sector), 16'(want.sector));
          check_field("volume_count", 16'(rsp_if.data.volume_count),
                      16'(want.volume_count));
        end
      end
      if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
        pending_results.push_back(map_request(req_if.data));
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("[volume_table_block_mapper] ERROR");
        $finish;
      end
    end
  end

  // result side: random ready gaps, plus a long hold-off on request
  initial begin : rsp_sink
    int unsigned w;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rsp_hold_cycles != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (rsp_hold_cycles) @(posedge clk);
        rsp_hold_cycles = 0;
      end
      w = no_gaps ? 0 : $urandom_range(0, 9);
      if (w != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
    end
  end

  function automatic vtbm_req_t build_request(input logic [1:0] op,
                                              input int unsigned cyl, input int unsigned sec,
                                              input int unsigned count,
                                              input int unsigned kind,
                                              input int unsigned vol, input int unsigned blk);
    vtbm_req_t r;
    r.req_type       = op;
    r.first_cylinder = 10'(cyl);
    r.first_sector   = 4'(sec);
    r.sector_count   = 16'(count);
    r.vol_type       = 2'(kind);
    r.volume_index   = 3'(vol);
    r.block_number   = 16'(blk);
    return r;
  endfunction

  task automatic send_request(input vtbm_req_t r);
    int unsigned w;
    if (r.req_type == REQ_CREATE && planned_sizes.size() < MAX_VOLUMES)
      planned_sizes.push_back(32'(r.sector_count));
    else if (r.req_type == REQ_DELETE && r.volume_index < planned_sizes.size())
      planned_sizes.delete(32'(r.volume_index));
    w = no_gaps ? 0 : $urandom_range(0, 9);
    if (w != 0) begin
      req_if.valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (req_if.ready !== 1'b1);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic vtbm_req_t random_request();
    vtbm_req_t   r;
    int unsigned pick;
    int unsigned size_of_vol;
    r.req_type       = 2'($urandom);
    r.first_cylinder = 10'($urandom);
    r.first_sector   = 4'($urandom);
    r.vol_type       = 2'($urandom);
    r.volume_index   = 3'($urandom);
    r.block_number   = 16'($urandom);
    case ($urandom_range(0, 3))
      0: r.sector_count = 16'($urandom_range(0, 20));
      1: r.sector_count = 16'($urandom_range(0, 255));
      2: r.sector_count = 16'hffff;
      default: r.sector_count = 16'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 30)
      r.req_type = REQ_CREATE;
    else if (pick < 58)
      r.req_type = REQ_DELETE;
    else if (pick < 96)
      r.req_type = REQ_TRANSLATE;
    else
      r.req_type = REQ_UNUSED;
    // mostly aim at volumes that exist and blocks inside them
    if (planned_sizes.size() != 0 && $urandom_range(0, 9) < 8)
      r.volume_index = 3'($urandom_range(0, planned_sizes.size() - 1));
    if (r.req_type == REQ_TRANSLATE && r.volume_index < planned_sizes.size()) begin
      size_of_vol = planned_sizes[r.volume_index];
      pick = $urandom_range(0, 99);
      if (size_of_vol != 0 && pick < 75)
        r.block_number = 16'($urandom_range(0, size_of_vol - 1));
      else if (pick < 87)
        r.block_number = 16'(size_of_vol);
    end
    return r;
  endfunction

  task automatic test_directed();
    int k;
    // empty table: nothing to delete or translate
    send_request(build_request(REQ_TRANSLATE, 0, 0, 0, 0, 0, 0));
    send_request(build_request(REQ_DELETE, 0, 0, 0, 0, 0, 0));
    // zero-sector volume has no valid block
    send_request(build_request(REQ_CREATE, 0, 0, 0, 0, 0, 0));
    send_request(build_request(REQ_TRANSLATE, 0, 0, 0, 0, 0, 0));
    // all-ones volume: largest cylinder, last block, one past it
    send_request(build_request(REQ_CREATE, 1023, 15, 65535, 3, 7, 65535));
    send_request(build_request(REQ_TRANSLATE, 0, 0, 0, 0, 1, 65534));
    send_request(build_request(REQ_TRANSLATE, 0, 0, 0, 0, 1, 65535));
    send_request(build_request(REQ_TRANSLATE, 0, 0, 0, 0, 1, 0));
    send_request(build_request(REQ_CREATE, 5, 3, 1, 1, 0, 0));
    send_request(build_request(REQ_TRANSLATE, 0, 0, 0, 0, 2, 0));
    send_request(build_request(REQ_TRANSLATE, 0, 0, 0, 0, 2, 1));
    for (k = 0; k < 5; k++)
      send_request(build_request(REQ_CREATE, 100 * k + 7, 3 * k, 100 + k, 2, 0, 0));
    // table full
    send_request(build_request(REQ_CREATE, 1, 1, 1, 1, 0, 0));
    send_request(build_request(REQ_TRANSLATE, 0, 0, 0, 0, 7, 99));
    // delete in the middle, then the shifted entry is read back
    send_request(build_request(REQ_DELETE, 0, 0, 0, 0, 3, 0));
    send_request(build_request(REQ_TRANSLATE, 0, 0, 0, 0, 3, 17));
    send_request(build_request(REQ_DELETE, 0, 0, 0, 0, 0, 0));
    send_request(build_request(REQ_DELETE, 0, 0, 0, 0, 5, 0));
    send_request(build_request(REQ_DELETE, 0, 0, 0, 0, 7, 0));
    send_request(build_request(REQ_TRANSLATE, 0, 0, 0, 0, 5, 0));
    send_request(build_request(REQ_UNUSED, 1023, 15, 65535, 3, 7, 65535));
    wait_drained();
  endtask

  task automatic test_output_stall();
    int k;
    no_gaps = 1'b1;
    rsp_hold_cycles = 40;
    for (k = 0; k < 24; k++)
      send_request(random_request());
    wait_drained();
    no_gaps = 1'b0;
  endtask

  task automatic test_random();
    int k;
    for (k = 0; k < RANDOM_REQUESTS; k++) begin
      if (k % PHASE_LEN == 0) begin
        wait_drained();
        // alternate phases with and without idle cycles
        no_gaps = ((k / PHASE_LEN) % 2) == 1;
      end
      send_request(random_request());
    end
    wait_drained();
    no_gaps = 1'b0;
  endtask

  initial begin
    mismatches      = 0;
    no_gaps         = 1'b0;
    rsp_hold_cycles = 0;
    volume_total    = 0;
    rst             <= 1'b1;
    req_if.valid    <= 1'b0;
    req_if.data     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_output_stall();
    test_random();
    test_output_stall();
    wait_drained();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[volume_table_block_mapper] OK");
    end else begin
      $display("[volume_table_block_mapper] ERROR");
    end
    $finish;
  end

endmodule

>>> volume_table_block_mapper.f
hw/rtl/vtbm_pkg.sv
hw/rtl/vtbm_req_if.sv
hw/rtl/vtbm_rsp_if.sv
hw/rtl/vtbm_cell.sv
hw/rtl/volume_table_block_mapper.sv
tb/volume_table_block_mapper_tb.sv
